>>> rtl/sng_pkg.sv
// ----------------------------------------------------------------------------
// sng_pkg
// Shared types, constants and helpers of the spectral noise gate.
// ----------------------------------------------------------------------------
package sng_pkg;

  localparam int unsigned BIN_FW   = 10;
  localparam int unsigned PART_W   = 24;
  localparam int unsigned BINPK_W  = 48;
  localparam int unsigned NOISE_W  = 48;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PWR_W    = 48;
  localparam int unsigned RP_W     = 56;
  localparam int unsigned DEN_W    = 58;
  localparam int unsigned REM_W    = 59;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned SQ_STAGES = 6;

  localparam int unsigned S_TDATA_W = 112;
  localparam int unsigned M_TDATA_W = 80;
  localparam int unsigned OUT_WORD_W = BIN_FW + 2 * PART_W + GAIN_W;

  localparam int unsigned OUT_DEPTH = 32;
  localparam int unsigned OUT_PTR_W = 5;
  localparam int unsigned OUT_CNT_W = 6;

  localparam logic [GAIN_W-1:0] Q15_ONE = 16'd32768;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic {
    OP_PROCESS = 1'b0,
    OP_LOAD    = 1'b1
  } sng_op_e;

  typedef enum logic [1:0] {
    REG_MIN_GAIN  = 2'd0,
    REG_SHARPNESS = 2'd1,
    REG_FRAMES    = 2'd2,
    REG_NONE      = 2'd3
  } sng_reg_e;

  // sideband that rides along with the divider
  typedef struct packed {
    logic                nz;
    logic [BIN_FW-1:0]   bin;
    logic [BINPK_W-1:0]  delayed;
  } sng_tag_t;

  function automatic logic [PART_W-1:0] mag24(input logic [PART_W-1:0] v);
    mag24 = v[PART_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [PWR_W-1:0] power48(input logic [BINPK_W-1:0] p);
    logic [PART_W-1:0] a;
    logic [PART_W-1:0] b;
    a = mag24(p[PART_W-1:0]);
    b = mag24(p[BINPK_W-1:PART_W]);
    power48 = PWR_W'(a * a) + PWR_W'(b * b);
  endfunction

endpackage

>>> rtl/sng_ram.sv
// ----------------------------------------------------------------------------
// sng_ram
// Simple dual-port RAM, one write and one registered read, read-first.
// ----------------------------------------------------------------------------
module sng_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 513
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sng_div.sv
// ----------------------------------------------------------------------------
// sng_div
// Pipelined restoring divider, one quotient bit per stage, Q1.15 fraction.
// ----------------------------------------------------------------------------
module sng_div
  import sng_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RP_W-1:0]   num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  sng_tag_t          tag_i,
  output logic              valid_o,
  output logic [FRAC_W-1:0] frac_o,
  output sng_tag_t          tag_o
);

  logic              v_q   [DIV_STEPS];
  logic [REM_W-1:0]  rem_q [DIV_STEPS];
  logic [DEN_W-1:0]  den_q [DIV_STEPS];
  logic [FRAC_W-1:0] f_q   [DIV_STEPS];
  sng_tag_t          tag_q [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [FRAC_W-1:0] f_in;
    sng_tag_t          tag_in;
    logic              ge;
    logic [REM_W-1:0]  rem_sub;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = REM_W'(num_i);
      assign den_in = den_i;
      assign f_in   = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign f_in   = f_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign ge      = rem_in >= REM_W'(den_in);
    assign rem_sub = ge ? (rem_in - REM_W'(den_in)) : rem_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= {rem_sub[REM_W-2:0], 1'b0};
      den_q[s] <= den_in;
      f_q[s]   <= {f_in[FRAC_W-2:0], ge};
      tag_q[s] <= tag_in;
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign frac_o  = f_q[DIV_STEPS-1];
  assign tag_o   = tag_q[DIV_STEPS-1];

endmodule

>>> rtl/spectral_noise_gate_unit.sv
// ----------------------------------------------------------------------------
// spectral_noise_gate_unit
// Per-bin spectral noise gate over a ring of frames held in block RAM.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel; tuser selects process (0) or
// noise load (1). A processed bin updates the bin's running power, computes
// the gate gain through a 16-stage divider and up to six squaring stages,
// and emits the bin from frames_to_average/2 frames back, scaled by the gain.
// Loads and bins above FFT_SIZE/2 emit nothing.
// One word is taken per cycle while s_axis_tready is high; a processed bin
// runs through stages 1-3, divider, squaring, gain and apply into the queue.
// Results collect in a 32-word output queue; when the receiver stalls the
// queue fills and s_axis_tready drops once every queue slot is spoken for.
// After reset, and after each write of frames_to_average, a clearing pass over
// all MAX_FRAMES*(FFT_SIZE/2+1) ring entries zeroes the frame ring and running
// power (after reset the noise table too); s_axis_tready stays low meanwhile.
// Registers go through the APB port at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module spectral_noise_gate_unit
  import sng_pkg::*;
#(
  parameter int unsigned FFT_SIZE   = 1024,
  parameter int unsigned MAX_FRAMES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // bin_index, bin_real, bin_imag, noise_power
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_bin_index, gated_real, gated_imag, applied_gain
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned NBINS  = FFT_SIZE / 2 + 1;
  localparam int unsigned HDEPTH = MAX_FRAMES * NBINS;
  localparam int unsigned BIN_W  = $clog2(NBINS);
  localparam int unsigned HA_W   = $clog2(HDEPTH);
  localparam int unsigned M_W    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  // ---------------- configuration ----------------
  logic [15:0] min_gain_q;
  logic [2:0]  sharp_q;
  logic [3:0]  frames_q;
  logic        cfg_we;
  sng_reg_e    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = sng_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gain_q <= 16'd328;
      sharp_q    <= 3'd1;
      frames_q   <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_MIN_GAIN:  min_gain_q <= pwdata[15:0];
        REG_SHARPNESS: sharp_q    <= pwdata[2:0];
        REG_FRAMES:    frames_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MIN_GAIN:  prdata = 32'(min_gain_q);
      REG_SHARPNESS: prdata = 32'(sharp_q);
      REG_FRAMES:    prdata = 32'(frames_q);
      default:       prdata = '0;
    endcase
  end

  logic [M_W-1:0] m_eff;
  always_comb begin
    if (frames_q == 4'd0) begin
      m_eff = M_W'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      m_eff = M_W'(MAX_FRAMES);
    end else begin
      m_eff = M_W'(frames_q);
    end
  end

  logic [M_W-1:0]    dly_init_w;
  logic [SLOT_W-1:0] dly_init;
  assign dly_init_w = m_eff - (m_eff >> 1);
  assign dly_init   = (dly_init_w >= m_eff) ? '0 : SLOT_W'(dly_init_w);

  // ---------------- clearing pass ----------------
  logic            clr_q, clr_d;
  logic            clr_noise_q, clr_noise_d;
  logic [HA_W-1:0] clr_cnt_q, clr_cnt_d;
  logic            clr_low;

  assign clr_low = {1'b0, clr_cnt_q} < (HA_W + 1)'(NBINS);

  always_comb begin
    clr_d       = clr_q;
    clr_noise_d = clr_noise_q;
    clr_cnt_d   = clr_cnt_q;
    if (cfg_we && cfg_sel == REG_FRAMES) begin
      clr_d     = 1'b1;
      clr_cnt_d = '0;
    end else if (clr_q) begin
      if (clr_cnt_q == HA_W'(HDEPTH - 1)) begin
        clr_d       = 1'b0;
        clr_noise_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_noise_q <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      clr_q       <= clr_d;
      clr_noise_q <= clr_noise_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  // ---------------- input accept ----------------
  logic [OUT_CNT_W-1:0] occ_q, occ_d;
  logic                 acc, in_rng, proc, load, top_bin;
  logic [BIN_FW-1:0]    in_bin;
  logic [BINPK_W-1:0]   in_cur;
  logic [NOISE_W-1:0]   in_noise;
  logic [BIN_W-1:0]     bin_a;
  logic                 pop;

  assign in_bin   = s_axis_tdata[BIN_FW-1:0];
  assign in_cur   = s_axis_tdata[BIN_FW+BINPK_W-1:BIN_FW];
  assign in_noise = s_axis_tdata[BIN_FW+BINPK_W+NOISE_W-1:BIN_FW+BINPK_W];
  assign bin_a    = BIN_W'(in_bin);

  assign s_axis_tready = !clr_q && (occ_q < OUT_CNT_W'(OUT_DEPTH));
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign in_rng  = 32'(in_bin) < NBINS;
  assign proc    = acc && in_rng && (sng_op_e'(s_axis_tuser) == OP_PROCESS);
  assign load    = acc && in_rng && (sng_op_e'(s_axis_tuser) == OP_LOAD);
  assign top_bin = 32'(in_bin) == NBINS - 1;

  // frame slots
  logic [SLOT_W-1:0] new_slot_q, new_slot_d, dly_slot_q, dly_slot_d;
  logic [M_W-1:0]    new_nx, dly_nx;

  assign new_nx = M_W'(new_slot_q) + 1'b1;
  assign dly_nx = M_W'(dly_slot_q) + 1'b1;

  always_comb begin
    new_slot_d = new_slot_q;
    dly_slot_d = dly_slot_q;
    if (clr_q) begin
      new_slot_d = '0;
      dly_slot_d = dly_init;
    end else if (proc && top_bin) begin
      new_slot_d = (new_nx >= m_eff) ? '0 : SLOT_W'(new_nx);
      dly_slot_d = (dly_nx >= m_eff) ? '0 : SLOT_W'(dly_nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_slot_q <= '0;
      dly_slot_q <= '0;
    end else begin
      new_slot_q <= new_slot_d;
      dly_slot_q <= dly_slot_d;
    end
  end

  logic [HA_W-1:0] new_addr, dly_addr;
  assign new_addr = HA_W'(new_slot_q) * HA_W'(NBINS) + HA_W'(bin_a);
  assign dly_addr = HA_W'(dly_slot_q) * HA_W'(NBINS) + HA_W'(bin_a);

  // ---------------- memories ----------------
  logic               h_we;
  logic [HA_W-1:0]    h_waddr;
  logic [BINPK_W-1:0] h_wdata, h_old, h_dly;

  assign h_we    = clr_q || proc;
  assign h_waddr = clr_q ? clr_cnt_q : new_addr;
  assign h_wdata = clr_q ? '0 : in_cur;

  sng_ram #(.WIDTH(BINPK_W), .DEPTH(HDEPTH)) u_hist_new (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(new_addr), .rdata_o(h_old)
  );

  sng_ram #(.WIDTH(BINPK_W), .DEPTH(HDEPTH)) u_hist_dly (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(dly_addr), .rdata_o(h_dly)
  );

  logic               rp_we;
  logic [BIN_W-1:0]   rp_waddr;
  logic [RP_W-1:0]    rp_wdata, rp_rd;
  logic               nz_we;
  logic [BIN_W-1:0]   nz_waddr;
  logic [NOISE_W-1:0] nz_wdata, nz_rd;

  sng_ram #(.WIDTH(RP_W), .DEPTH(NBINS)) u_power (
    .clk_i, .we_i(rp_we), .waddr_i(rp_waddr), .wdata_i(rp_wdata),
    .raddr_i(bin_a), .rdata_o(rp_rd)
  );

  assign nz_we    = load || (clr_q && clr_noise_q && clr_low);
  assign nz_waddr = clr_q ? BIN_W'(clr_cnt_q) : bin_a;
  assign nz_wdata = clr_q ? '0 : in_noise;

  sng_ram #(.WIDTH(NOISE_W), .DEPTH(NBINS)) u_noise (
    .clk_i, .we_i(nz_we), .waddr_i(nz_waddr), .wdata_i(nz_wdata),
    .raddr_i(bin_a), .rdata_o(nz_rd)
  );

  // ---------------- stage 1: read data, power ----------------
  logic               v1_q;
  logic [BIN_FW-1:0]  bin1_q;
  logic [BINPK_W-1:0] cur1_q;
  logic               self1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= proc;
    end
  end

  always_ff @(posedge clk_i) begin
    bin1_q  <= in_bin;
    cur1_q  <= in_cur;
    self1_q <= new_slot_q == dly_slot_q;
  end

  // running power forwarding: stage 2 write in flight, then last write
  logic               v2_q;
  logic [BIN_FW-1:0]  bin2_q;
  logic [RP_W-1:0]    rp_new;
  logic               lw_v_q;
  logic [BIN_FW-1:0]  lw_bin_q;
  logic [RP_W-1:0]    lw_rp_q;
  logic [RP_W-1:0]    rp_fwd;

  always_comb begin
    priority if (v2_q && bin2_q == bin1_q) begin
      rp_fwd = rp_new;
    end else if (lw_v_q && lw_bin_q == bin1_q) begin
      rp_fwd = lw_rp_q;
    end else begin
      rp_fwd = rp_rd;
    end
  end

  logic [BINPK_W-1:0] dly2_q;
  logic [PWR_W-1:0]   pold2_q, pnew2_q;
  logic [RP_W-1:0]    rpo2_q;
  logic [NOISE_W-1:0] noise2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      lw_v_q <= 1'b0;
    end else begin
      v2_q   <= v1_q;
      lw_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin2_q   <= bin1_q;
    dly2_q   <= self1_q ? cur1_q : h_dly;
    pold2_q  <= power48(h_old);
    pnew2_q  <= power48(cur1_q);
    rpo2_q   <= rp_fwd;
    noise2_q <= nz_rd;
    lw_bin_q <= bin2_q;
    lw_rp_q  <= rp_new;
  end

  // ---------------- stage 2: running power update ----------------
  logic [RP_W-1:0] rp_sub;
  assign rp_sub = (rpo2_q >= RP_W'(pold2_q)) ? (rpo2_q - RP_W'(pold2_q)) : '0;
  assign rp_new = rp_sub + RP_W'(pnew2_q);

  assign rp_we    = v2_q || (clr_q && clr_low);
  assign rp_waddr = clr_q ? BIN_W'(clr_cnt_q) : BIN_W'(bin2_q);
  assign rp_wdata = clr_q ? '0 : rp_new;

  logic                   v3_q;
  logic [RP_W-1:0]        rp3_q;
  logic [NOISE_W+M_W-1:0] mn3_q;
  logic [BINPK_W-1:0]     dly3_q;
  logic [BIN_FW-1:0]      bin3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rp3_q  <= rp_new;
    mn3_q  <= (NOISE_W + M_W)'(noise2_q) * (NOISE_W + M_W)'(m_eff);
    dly3_q <= dly2_q;
    bin3_q <= bin2_q;
  end

  // ---------------- stage 3: denominator, divider ----------------
  logic [DEN_W-1:0]  den3;
  sng_tag_t          tag3, dtag;
  logic              dv;
  logic [FRAC_W-1:0] dfrac;

  assign den3        = DEN_W'(rp3_q) + DEN_W'(mn3_q);
  assign tag3.nz     = rp3_q != '0;
  assign tag3.bin    = bin3_q;
  assign tag3.delayed = dly3_q;

  sng_div u_div (
    .clk_i, .rst_ni,
    .valid_i(v3_q), .num_i(rp3_q), .den_i(den3), .tag_i(tag3),
    .valid_o(dv), .frac_o(dfrac), .tag_o(dtag)
  );

  // ---------------- sharpening: repeated squaring ----------------
  logic [2:0]        sq_n;
  logic              sq_v_q   [SQ_STAGES];
  logic [FRAC_W-1:0] sq_f_q   [SQ_STAGES];
  sng_tag_t          sq_tag_q [SQ_STAGES];

  assign sq_n = (sharp_q == 3'd0) ? 3'd0 : sharp_q - 3'd1;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    logic              v_in;
    logic [FRAC_W-1:0] f_in;
    sng_tag_t          t_in;
    logic [2*FRAC_W-1:0] sq;

    if (k == 0) begin : g_first
      assign v_in = dv;
      assign f_in = dtag.nz ? dfrac : '0;
      assign t_in = dtag;
    end else begin : g_next
      assign v_in = sq_v_q[k-1];
      assign f_in = sq_f_q[k-1];
      assign t_in = sq_tag_q[k-1];
    end

    assign sq = f_in * f_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else begin
        sq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_f_q[k]   <= (3'(k) < sq_n) ? sq[FRAC_W+14:15] : f_in;
      sq_tag_q[k] <= t_in;
    end
  end

  // ---------------- gain ----------------
  logic [GAIN_W-1:0]   g0, gspan;
  logic [2*GAIN_W-1:0] gprod;
  logic                gn_v_q;
  logic [GAIN_W-1:0]   gn_g_q;
  sng_tag_t            gn_tag_q;

  assign g0    = (min_gain_q > Q15_ONE) ? Q15_ONE : min_gain_q;
  assign gspan = Q15_ONE - g0;
  assign gprod = gspan * sq_f_q[SQ_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gn_v_q <= 1'b0;
    end else begin
      gn_v_q <= sq_v_q[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    gn_g_q   <= g0 + gprod[GAIN_W+14:15];
    gn_tag_q <= sq_tag_q[SQ_STAGES-1];
  end

  // ---------------- apply gain, round half away from zero ----------------
  logic [PART_W-1:0]        re_in, im_in, re_mag, im_mag, re_r, im_r, re_o, im_o;
  logic [PART_W+GAIN_W-1:0] re_p, im_p;
  logic                     ap_v_q;
  logic [OUT_WORD_W-1:0]    ap_word_q;

  assign re_in  = gn_tag_q.delayed[PART_W-1:0];
  assign im_in  = gn_tag_q.delayed[BINPK_W-1:PART_W];
  assign re_mag = mag24(re_in);
  assign im_mag = mag24(im_in);
  assign re_p   = re_mag * gn_g_q + (PART_W + GAIN_W)'(16384);
  assign im_p   = im_mag * gn_g_q + (PART_W + GAIN_W)'(16384);
  assign re_r   = re_p[PART_W+14:15];
  assign im_r   = im_p[PART_W+14:15];
  assign re_o   = re_in[PART_W-1] ? (~re_r + 1'b1) : re_r;
  assign im_o   = im_in[PART_W-1] ? (~im_r + 1'b1) : im_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ap_v_q <= 1'b0;
    end else begin
      ap_v_q <= gn_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ap_word_q <= {gn_g_q, im_o, re_o, gn_tag_q.bin};
  end

  // ---------------- output queue ----------------
  logic [OUT_WORD_W-1:0] q_mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  q_wp_q, q_rp_q;
  logic [OUT_CNT_W-1:0]  q_cnt_q;

  assign m_axis_tvalid = q_cnt_q != '0;
  assign m_axis_tdata  = M_TDATA_W'(q_mem_q[q_rp_q]);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (ap_v_q) begin
      q_mem_q[q_wp_q] <= ap_word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wp_q  <= '0;
      q_rp_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (ap_v_q) q_wp_q <= q_wp_q + 1'b1;
      if (pop)    q_rp_q <= q_rp_q + 1'b1;
      q_cnt_q <= q_cnt_q + OUT_CNT_W'(ap_v_q) - OUT_CNT_W'(pop);
    end
  end

  // slots reserved from accept until the word leaves the queue
  assign occ_d = occ_q + OUT_CNT_W'(proc) - OUT_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("reserved output slots exceed queue depth");

  a_queue_le_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= occ_q)
    else $error("queue holds more words than were reserved");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ap_v_q |-> (q_cnt_q < OUT_CNT_W'(OUT_DEPTH)) || pop)
    else $error("push into full output queue");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready && !v1_q)
    else $error("bin taken during clearing pass");

  a_fwd_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |=> lw_v_q && (lw_rp_q == $past(rp_new)))
    else $error("power write record lost");
`endif

endmodule

>>> tb/sv/spectral_noise_gate_unit_test.sv
// ----------------------------------------------------------------------------
// spectral_noise_gate_unit_test
// Self-checking bench for the spectral noise gate.
// ----------------------------------------------------------------------------
// Bins and noise loads stream in on s_axis and gated bins are checked on
// m_axis against a predictor that keeps its own frame ring, power sums and
// noise table. The run walks through several register settings, the extremes
// among them, with bursty input, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
module spectral_noise_gate_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sng_pkg::*;

  localparam int unsigned NB        = 513;
  localparam int unsigned TOP_BIN   = 512;
  localparam int unsigned RING_N    = 8;
  localparam int unsigned CYCLE_CAP = 1000000;

  typedef struct {
    sng_op_e           op;
    logic [BIN_FW-1:0] bin;
    logic [23:0]       re;
    logic [23:0]       im;
    logic [47:0]       noise;
  } bin_word_t;

  typedef struct {
    logic [BIN_FW-1:0] bin;
    logic [23:0]       re;
    logic [23:0]       im;
    logic [15:0]       gain;
  } gated_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  spectral_noise_gate_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [47:0] ring_hist [RING_N*NB];
  logic [55:0] pwr_sum [NB];
  logic [47:0] noise_ref [NB];
  int unsigned newest, delayed;
  logic [15:0] floor_gain;
  logic [2:0] sharp;
  logic [3:0] win;

  bin_word_t   pend_q[$];
  gated_word_t gated_q[$];
  int errors = 0, n_proc = 0, n_load = 0, n_skip = 0, n_out = 0;
  bit no_gaps = 0;
  int hold_trig = 0;

  function automatic int unsigned win_len();
    if (win == 0) return 1;
    if (win > RING_N) return RING_N;
    return win;
  endfunction

  function automatic void reset_ring();
    int unsigned m;
    m = win_len();
    foreach (ring_hist[i]) ring_hist[i] = '0;
    foreach (pwr_sum[i]) pwr_sum[i] = '0;
    newest = 0;
    delayed = m - m / 2;
    if (delayed >= m) delayed = 0;
  endfunction

  function automatic logic [23:0] abs24(logic [23:0] v);
    return v[23] ? 24'(-v) : v;
  endfunction

  function automatic logic [63:0] bin_power(logic [47:0] p);
    logic [63:0] a, b;
    a = 64'(abs24(p[23:0]));
    b = 64'(abs24(p[47:24]));
    return a * a + b * b;
  endfunction

  function automatic logic [23:0] scale_part(logic [23:0] v, logic [31:0] g);
    logic [63:0] r;
    r = (64'(abs24(v)) * 64'(g) + 64'd16384) >> 15;
    return v[23] ? 24'(-r[23:0]) : r[23:0];
  endfunction

  function automatic void gate_word(bin_word_t w);
    int unsigned m, b;
    logic [47:0] cur, dly;
    logic [63:0] pold, pnew;
    logic [55:0] rp;
    logic [127:0] den, q;
    logic [31:0] f, g0, g;
    gated_word_t r;
    m = win_len();
    b = w.bin;
    if (b > TOP_BIN) begin
      n_skip++;
      return;
    end
    if (w.op == OP_LOAD) begin
      noise_ref[b] = w.noise;
      n_load++;
      return;
    end
    n_proc++;
    cur = {w.im, w.re};
    pnew = bin_power(cur);
    pold = bin_power(ring_hist[newest*NB + b]);
    rp = pwr_sum[b];
    rp = (64'(rp) >= pold) ? 56'(64'(rp) - pold) : '0;
    rp = 56'(rp + pnew);
    pwr_sum[b] = rp;
    ring_hist[newest*NB + b] = cur;
    dly = ring_hist[delayed*NB + b];
    f = 0;
    if (rp != 0) begin
      den = 128'(rp) + 128'(m) * 128'(noise_ref[b]);
      q = (128'(rp) << 15) / den;
      f = q[31:0];
    end
    for (int i = 1; i < sharp; i++) f = (f * f) >> 15;
    g0 = (floor_gain > 16'd32768) ? 32'd32768 : 32'(floor_gain);
    g = g0 + 32'((64'(32768 - g0) * 64'(f)) >> 15);
    r.bin = w.bin;
    r.re = scale_part(dly[23:0], g);
    r.im = scale_part(dly[47:24], g);
    r.gain = g[15:0];
    gated_q.push_back(r);
    if (b == TOP_BIN) begin
      if (++newest >= m) newest = 0;
      if (++delayed >= m) delayed = 0;
    end
  endfunction

  // sender: bursts with random gaps
  bin_word_t cur_w;
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) gate_word(cur_w);
      if (!(s_axis_tvalid && !take)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur_w = pend_q.pop_front();
          s_axis_tdata <= {6'd0, cur_w.noise, cur_w.im, cur_w.re, cur_w.bin};
          s_axis_tuser <= cur_w.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall rate redrawn from four levels, long hold on request
  int stall_pct = 0, stall_age = 0, hold_seen = 0, hold_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (++stall_age == 64) begin
        stall_age = 0;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    gated_word_t e, a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.bin = m_axis_tdata[9:0];
      a.re = m_axis_tdata[33:10];
      a.im = m_axis_tdata[57:34];
      a.gain = m_axis_tdata[73:58];
      n_out++;
      if (gated_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word bin=%0d re=%h im=%h gain=%0d",
                 $realtime, a.bin, a.re, a.im, a.gain);
      end else begin
        e = gated_q.pop_front();
        if (a.bin !== e.bin) begin
          errors++;
          $display("%0t: bin exp %0d got %0d", $realtime, e.bin, a.bin);
        end
        if (a.re !== e.re) begin
          errors++;
          $display("%0t: gated_real exp %h got %h", $realtime, e.re, a.re);
        end
        if (a.im !== e.im) begin
          errors++;
          $display("%0t: gated_imag exp %h got %h", $realtime, e.im, a.im);
        end
        if (a.gain !== e.gain) begin
          errors++;
          $display("%0t: gain exp %0d got %0d", $realtime, e.gain, a.gain);
        end
      end
    end
  end

  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    if (++cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("spectral_noise_gate_unit: mismatch");
      $finish;
    end
  end

  task automatic reg_write(sng_reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'({r, 2'b00});
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_MIN_GAIN: floor_gain = v[15:0];
      REG_SHARPNESS: sharp = v[2:0];
      REG_FRAMES: begin
        win = v[3:0];
        reset_ring();
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pend_q.size() == 0 && !s_axis_tvalid && gated_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'(signed'($urandom_range(0, 512)) - 256);
      3: return '0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [BIN_FW-1:0] rand_bin();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return BIN_FW'($urandom_range(0, 7));
    if (k < 62) return BIN_FW'(TOP_BIN);
    if (k < 72) return BIN_FW'($urandom_range(508, 511));
    if (k < 92) return BIN_FW'($urandom_range(0, TOP_BIN));
    return BIN_FW'($urandom_range(TOP_BIN + 1, 1023));
  endfunction

  function automatic bin_word_t rand_word();
    bin_word_t w;
    w.op = ($urandom_range(0, 99) < 12) ? OP_LOAD : OP_PROCESS;
    w.bin = rand_bin();
    w.re = rand_part();
    w.im = rand_part();
    w.noise = 48'({$urandom, $urandom} >> $urandom_range(0, 48));
    if ($urandom_range(0, 9) == 0) w.noise = '1;
    return w;
  endfunction

  function automatic void push_word(sng_op_e op, int bin, logic [23:0] re,
                                    logic [23:0] im, logic [47:0] nz);
    bin_word_t w;
    w.op = op;
    w.bin = BIN_FW'(bin);
    w.re = re;
    w.im = im;
    w.noise = nz;
    pend_q.push_back(w);
  endfunction

  int unsigned gain_set[6] = '{328, 0, 32768, 65535, 16384, 1000};
  int unsigned sharp_set[6] = '{1, 5, 0, 7, 2, 3};
  int unsigned win_set[6] = '{5, 8, 1, 0, 15, 3};

  initial begin
    foreach (noise_ref[i]) noise_ref[i] = '0;
    floor_gain = 16'd328;
    sharp = 3'd1;
    win = 4'd5;
    reset_ring();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, loads, zero noise, out-of-range bins, ring advance
    push_word(OP_PROCESS, 0, 24'h7fffff, 24'h800000, '0);
    push_word(OP_PROCESS, TOP_BIN, 24'h800000, 24'h800000, '0);
    push_word(OP_LOAD, 0, '0, '0, 48'hffffffffffff);
    push_word(OP_LOAD, TOP_BIN, '0, '0, 48'd1000);
    push_word(OP_LOAD, 513, '0, '0, 48'd5);
    push_word(OP_PROCESS, 1023, 24'h7fffff, 24'h7fffff, '0);
    push_word(OP_LOAD, 1023, '0, '0, 48'd7);
    for (int k = 0; k < 6; k++) begin
      push_word(OP_PROCESS, 0, 24'h7fffff, 24'h000001, '0);
      push_word(OP_PROCESS, 1, '0, '0, '0);
      push_word(OP_PROCESS, TOP_BIN, 24'h800000, 24'h7fffff, '0);
    end
    push_word(OP_PROCESS, 511, 24'h000010, 24'hfffff0, '0);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        reg_write(REG_MIN_GAIN, {16'($urandom), 16'(gain_set[p])});
        reg_write(REG_SHARPNESS, {29'($urandom_range(0, 255)), 3'(sharp_set[p])});
        reg_write(REG_FRAMES, 32'(win_set[p]));
      end
      no_gaps = (p == 2);
      for (int k = 0; k < 250; k++) begin
        pend_q.push_back(rand_word());
        if (p == 3 && k == 125) begin
          wait (pend_q.size() == 0 && !s_axis_tvalid && gated_q.size() == 0);
        end
      end
      if (p == 2) hold_trig++;
      drain();
    end

    $display("covered %0d processed bins, %0d noise loads, %0d ignored words",
             n_proc, n_load, n_skip);
    $display("%0d gated words checked over 6 register settings", n_out);
    if (errors == 0) begin
      $display("spectral_noise_gate_unit: match");
    end else begin
      $display("spectral_noise_gate_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sng_pkg.sv
rtl/sng_ram.sv
rtl/sng_div.sv
rtl/spectral_noise_gate_unit.sv
tb/sv/spectral_noise_gate_unit_test.sv
